[design/cbs_pkg.sv]
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared constants, result codes and controller/datapath interface types
// for the counting bucket sort block.
// ----------------------------------------------------------------------------
package cbs_pkg;

    localparam int VALUE_BITS = 10;
    localparam int COUNT_BITS = 13;

    // Key split: high part picks a bitmap row, low part a bit in the row.
    localparam int LO_BITS  = (VALUE_BITS + 1) / 2;
    localparam int HI_BITS  = VALUE_BITS - LO_BITS;
    localparam int NUM_KEYS = 1 << VALUE_BITS;
    localparam int ROWS     = 1 << HI_BITS;
    localparam int ROW_W    = 1 << LO_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_POPPED   = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Controller to datapath.
    typedef struct packed {
        logic rd_ins;     // accept insert: read count and row at input key
        logic rd_row;     // accept pop: read row of lowest occupied row
        logic rd_cnt;     // pop: pick lowest bit, read its count
        logic wr_ins;     // finish insert, write result
        logic wr_pop;     // finish pop, write result
        logic out_empty;  // finish pop on empty store
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic empty;      // no key stored
        logic slot_free;  // result register can take a word this cycle
    } t_stat;

endpackage

[design/cbs_ram.sv]
// ----------------------------------------------------------------------------
// cbs_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module cbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/cbs_ctrl.sv]
// ----------------------------------------------------------------------------
// cbs_ctrl
// Sequencer for insert and pop requests; issues datapath commands.
// ----------------------------------------------------------------------------
module cbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_req_type,
    input  cbs_pkg::t_stat i_stat,
    output logic          o_stall,
    output cbs_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_POP_ROW,
        S_POP_CNT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_req_type) begin
                        o_cmd.rd_row = 1'b1;
                        n_state      = S_POP_ROW;
                    end else begin
                        o_cmd.rd_ins = 1'b1;
                        n_state      = S_INS;
                    end
                end
            end
            S_INS: begin
                if (i_stat.slot_free) begin
                    o_cmd.wr_ins = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_POP_ROW: begin
                if (i_stat.empty) begin
                    if (i_stat.slot_free) begin
                        o_cmd.out_empty = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.rd_cnt = 1'b1;
                    n_state      = S_POP_CNT;
                end
            end
            S_POP_CNT: begin
                if (i_stat.slot_free) begin
                    o_cmd.wr_pop = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE) | ~i_rst_n;

endmodule

[design/cbs_dp.sv]
// ----------------------------------------------------------------------------
// cbs_dp
// Datapath: count RAM, two-level occupancy bitmap, key register and
// result register.
// ----------------------------------------------------------------------------
module cbs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [cbs_pkg::VALUE_BITS-1:0]  i_value,
    input  logic                            i_stall,
    input  cbs_pkg::t_cmd                   i_cmd,
    output cbs_pkg::t_stat                  o_stat,
    output logic                            o_valid,
    output logic [1:0]                      o_status,
    output logic [cbs_pkg::VALUE_BITS-1:0]  o_sorted_value,
    output logic                            o_last
);

    // Lowest set bit of the row-occupancy summary.
    function automatic logic [cbs_pkg::HI_BITS-1:0] prio_hi(
        input logic [cbs_pkg::ROWS-1:0] v
    );
        logic [cbs_pkg::HI_BITS-1:0] idx;
        idx = '0;
        for (int i = cbs_pkg::ROWS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = cbs_pkg::HI_BITS'(i);
            end
        end
        return idx;
    endfunction

    // Lowest set bit within one bitmap row.
    function automatic logic [cbs_pkg::LO_BITS-1:0] prio_lo(
        input logic [cbs_pkg::ROW_W-1:0] v
    );
        logic [cbs_pkg::LO_BITS-1:0] idx;
        idx = '0;
        for (int i = cbs_pkg::ROW_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = cbs_pkg::LO_BITS'(i);
            end
        end
        return idx;
    endfunction

    // Summary bit per row; a row whose bit is clear reads as all zero,
    // and a key whose bitmap bit is clear has count zero, so neither
    // RAM needs clearing after reset.
    logic [cbs_pkg::ROWS-1:0]         r_summary;
    logic [cbs_pkg::VALUE_BITS-1:0]   r_key;
    logic [cbs_pkg::ROW_W-1:0]        r_row;
    logic                             r_out_valid;
    logic [1:0]                       r_status;
    logic [cbs_pkg::VALUE_BITS-1:0]   r_sorted;
    logic                             r_last;

    logic [cbs_pkg::HI_BITS-1:0]      key_hi;
    logic [cbs_pkg::LO_BITS-1:0]      key_lo;
    logic [cbs_pkg::HI_BITS-1:0]      min_hi;
    logic [cbs_pkg::LO_BITS-1:0]      pop_lo;

    logic [cbs_pkg::COUNT_BITS-1:0]   cnt_rdata;
    logic [cbs_pkg::ROW_W-1:0]        row_rdata;
    logic [cbs_pkg::VALUE_BITS-1:0]   cnt_raddr;
    logic [cbs_pkg::HI_BITS-1:0]      row_raddr;
    logic                             cnt_we;
    logic [cbs_pkg::COUNT_BITS-1:0]   cnt_wdata;
    logic                             row_we;
    logic [cbs_pkg::ROW_W-1:0]        row_wdata;

    logic [cbs_pkg::ROW_W-1:0]        row_eff;
    logic [cbs_pkg::ROW_W-1:0]        lo_mask;
    logic [cbs_pkg::ROWS-1:0]         hi_mask;
    logic [cbs_pkg::COUNT_BITS-1:0]   cnt_eff;
    logic                             ins_full;
    logic [cbs_pkg::COUNT_BITS-1:0]   cnt_dec;
    logic [cbs_pkg::ROW_W-1:0]        row_clr;
    logic                             pop_drain;
    logic                             pop_last;

    assign key_hi = r_key[cbs_pkg::VALUE_BITS-1:cbs_pkg::LO_BITS];
    assign key_lo = r_key[cbs_pkg::LO_BITS-1:0];
    assign min_hi = prio_hi(r_summary);
    assign pop_lo = prio_lo(row_rdata);

    assign cnt_raddr = i_cmd.rd_ins ? i_value : {key_hi, pop_lo};
    assign row_raddr = i_cmd.rd_ins ? i_value[cbs_pkg::VALUE_BITS-1:cbs_pkg::LO_BITS]
                                    : min_hi;

    always_comb begin
        lo_mask         = '0;
        lo_mask[key_lo] = 1'b1;
        hi_mask         = '0;
        hi_mask[key_hi] = 1'b1;
    end

    // Insert side
    assign row_eff  = r_summary[key_hi] ? row_rdata : '0;
    assign cnt_eff  = row_eff[key_lo] ? cnt_rdata : '0;
    assign ins_full = (cnt_eff == cbs_pkg::COUNT_MAX);

    // Pop side
    assign cnt_dec   = cnt_rdata - cbs_pkg::COUNT_BITS'(1);
    assign row_clr   = r_row & ~lo_mask;
    assign pop_drain = (cnt_dec == '0);
    assign pop_last  = pop_drain && (row_clr == '0) && ((r_summary & ~hi_mask) == '0);

    always_comb begin
        cnt_we    = 1'b0;
        cnt_wdata = '0;
        row_we    = 1'b0;
        row_wdata = '0;
        if (i_cmd.wr_ins && !ins_full) begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_eff + cbs_pkg::COUNT_BITS'(1);
            row_we    = 1'b1;
            row_wdata = row_eff | lo_mask;
        end else if (i_cmd.wr_pop) begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_dec;
            row_we    = pop_drain;
            row_wdata = row_clr;
        end
    end

    cbs_ram #(
        .WIDTH (cbs_pkg::COUNT_BITS),
        .DEPTH (cbs_pkg::NUM_KEYS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_key),
        .i_wdata (cnt_wdata),
        .i_re    (i_cmd.rd_ins | i_cmd.rd_cnt),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    cbs_ram #(
        .WIDTH (cbs_pkg::ROW_W),
        .DEPTH (cbs_pkg::ROWS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (key_hi),
        .i_wdata (row_wdata),
        .i_re    (i_cmd.rd_ins | i_cmd.rd_row),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    // Key and saved row
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_ins) begin
            r_key <= i_value;
        end else if (i_cmd.rd_row) begin
            r_key <= {min_hi, cbs_pkg::LO_BITS'(0)};
        end else if (i_cmd.rd_cnt) begin
            r_key[cbs_pkg::LO_BITS-1:0] <= pop_lo;
            r_row                      <= row_rdata;
        end
    end

    // Row summary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_summary <= '0;
        end else if (i_cmd.wr_ins && !ins_full) begin
            r_summary[key_hi] <= 1'b1;
        end else if (i_cmd.wr_pop && pop_drain && (row_clr == '0)) begin
            r_summary[key_hi] <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.wr_ins || i_cmd.wr_pop || i_cmd.out_empty) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_ins) begin
            r_status <= ins_full ? cbs_pkg::ST_FULL : cbs_pkg::ST_INSERTED;
            r_sorted <= '0;
            r_last   <= 1'b0;
        end else if (i_cmd.wr_pop) begin
            r_status <= cbs_pkg::ST_POPPED;
            r_sorted <= r_key;
            r_last   <= pop_last;
        end else if (i_cmd.out_empty) begin
            r_status <= cbs_pkg::ST_EMPTY;
            r_sorted <= '0;
            r_last   <= 1'b0;
        end
    end

    assign o_stat.empty     = (r_summary == '0);
    assign o_stat.slot_free = ~r_out_valid | ~i_stall;

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_sorted_value = r_sorted;
    assign o_last         = r_last;

endmodule

[design/counting_bucket_sort.sv]
// ----------------------------------------------------------------------------
// counting_bucket_sort
// Counting sort store: insert keys, pop them back smallest first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one request word per accept, with
//   i_req_type 0 = insert i_value, 1 = pop the smallest stored key.
//   Output channel (o_valid / i_stall): exactly one result word per
//   request: status, popped key (zero unless popped) and a last flag set
//   when the pop drained the store.
//   Each request finishes before the next is accepted: an insert is a
//   read-modify-write of the count RAM (registered read port), and a pop
//   adds the bitmap row read before the count read.
//   The lowest key is found by a priority encoder over the row summary
//   register, then one over the selected bitmap row.
//   Reset: synchronous, active low. Summary bits clear, so the store is
//   empty immediately; no RAM clearing pass is needed.
//   A stalled result stays in the output register; the next request is
//   still taken and waits in the datapath until the register frees up.
// ----------------------------------------------------------------------------
module counting_bucket_sort (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_req_type,
    input  logic [cbs_pkg::VALUE_BITS-1:0] i_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_status,
    output logic [cbs_pkg::VALUE_BITS-1:0] o_sorted_value,
    output logic                           o_last
);

    cbs_pkg::t_cmd  cmd;
    cbs_pkg::t_stat stat;

    // Sequencer: one request in flight at a time.
    cbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_stall    (o_stall),
        .o_cmd      (cmd)
    );

    // Counts, occupancy bitmap and result register.
    cbs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value        (i_value),
        .i_stall        (i_stall),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_sorted_value (o_sorted_value),
        .o_last         (o_last)
    );

`ifndef ASSERT_OFF
    // An accepted request keeps the input side busy the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accept");

    // Only a pop result carries a key.
    a_value_only_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != cbs_pkg::ST_POPPED)) |-> (o_sorted_value == '0))
        else $error("nonzero key on non-pop result");

    // Last flag only on a successful pop.
    a_last_only_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_status == cbs_pkg::ST_POPPED))
        else $error("last set on non-pop result");

    // While a last result is shown, no insert has landed yet: store is empty.
    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> stat.empty)
        else $error("store not empty after last pop");
`endif

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for counting_bucket_sort. Request words are driven
// from a directed table, then random segments with a varying insert/pop
// mix, then a full drain and a pop on the empty store.
// A behavioral copy of the sort store predicts every result word; result
// words are compared in order, field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int VB = cbs_pkg::VALUE_BITS;

    // Request codes on i_req_type.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    // Generous bound on the run, in cycles.
    localparam int CYCLE_LIMIT = 100000;
    // Drain time after the last expected word.
    localparam int TAIL_CYCLES = 12;

    typedef struct packed {
        logic [1:0]    status;
        logic [VB-1:0] key;
        logic          last;
    } t_sort_result;

    // One directed step; when 'typed' is set, 'want' is the result read off
    // by hand, otherwise the predictor supplies it.
    typedef struct packed {
        logic          req;
        logic [VB-1:0] key;
        logic          typed;
        t_sort_result  want;
    } t_stim_row;

    logic          i_clk      = 1'b0;
    logic          i_rst_n    = 1'b0;
    logic          i_valid    = 1'b0;
    logic          i_req_type = 1'b0;
    logic [VB-1:0] i_value    = '0;
    logic          i_stall    = 1'b0;
    logic          o_stall;
    logic          o_valid;
    logic [1:0]    o_status;
    logic [VB-1:0] o_sorted_value;
    logic          o_last;

    counting_bucket_sort dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_sorted_value (o_sorted_value),
        .o_last         (o_last)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Directed table: empty pops, both key extremes, duplicates, ordering of
    // interleaved keys, last flag on drain, keys on bitmap row boundaries,
    // an insert below the scan position, and a pop carrying a nonzero value.
    // ------------------------------------------------------------------------
    t_stim_row directed_rows [0:24] = '{
        '{REQ_POP,    10'h000, 1'b1, '{cbs_pkg::ST_EMPTY,    10'h000, 1'b0}},
        '{REQ_INSERT, 10'h3FF, 1'b1, '{cbs_pkg::ST_INSERTED, 10'h000, 1'b0}},
        '{REQ_POP,    10'h3FF, 1'b1, '{cbs_pkg::ST_POPPED,   10'h3FF, 1'b1}},
        '{REQ_POP,    10'h000, 1'b1, '{cbs_pkg::ST_EMPTY,    10'h000, 1'b0}},
        '{REQ_INSERT, 10'h000, 1'b1, '{cbs_pkg::ST_INSERTED, 10'h000, 1'b0}},
        '{REQ_INSERT, 10'h000, 1'b1, '{cbs_pkg::ST_INSERTED, 10'h000, 1'b0}},
        '{REQ_INSERT, 10'h3FF, 1'b1, '{cbs_pkg::ST_INSERTED, 10'h000, 1'b0}},
        '{REQ_POP,    10'h000, 1'b1, '{cbs_pkg::ST_POPPED,   10'h000, 1'b0}},
        '{REQ_INSERT, 10'h2AA, 1'b1, '{cbs_pkg::ST_INSERTED, 10'h000, 1'b0}},
        '{REQ_INSERT, 10'h155, 1'b1, '{cbs_pkg::ST_INSERTED, 10'h000, 1'b0}},
        '{REQ_POP,    10'h000, 1'b1, '{cbs_pkg::ST_POPPED,   10'h000, 1'b0}},
        '{REQ_POP,    10'h000, 1'b1, '{cbs_pkg::ST_POPPED,   10'h155, 1'b0}},
        '{REQ_POP,    10'h000, 1'b1, '{cbs_pkg::ST_POPPED,   10'h2AA, 1'b0}},
        '{REQ_POP,    10'h000, 1'b1, '{cbs_pkg::ST_POPPED,   10'h3FF, 1'b1}},
        '{REQ_POP,    10'h000, 1'b1, '{cbs_pkg::ST_EMPTY,    10'h000, 1'b0}},
        '{REQ_INSERT, 10'h01F, 1'b0, '0},
        '{REQ_INSERT, 10'h020, 1'b0, '0},
        '{REQ_INSERT, 10'h3E0, 1'b0, '0},
        '{REQ_POP,    10'h000, 1'b0, '0},
        '{REQ_INSERT, 10'h001, 1'b0, '0},
        '{REQ_POP,    10'h000, 1'b0, '0},
        '{REQ_POP,    10'h000, 1'b0, '0},
        '{REQ_POP,    10'h000, 1'b0, '0},
        '{REQ_POP,    10'h000, 1'b0, '0},
        '{REQ_POP,    10'h3FF, 1'b0, '0}
    };

    // Pop share in percent for each random segment; the high ones drain the
    // store often so empty pops and last flags keep coming.
    int pop_mix [0:7] = '{30, 50, 65, 45, 25, 55, 50, 80};

    // ------------------------------------------------------------------------
    // Predictor state: one count per key, a scan start that never lies above
    // the smallest stored key, and the number of stored keys (unbounded).
    // ------------------------------------------------------------------------
    logic [cbs_pkg::COUNT_BITS-1:0] key_tally [0:cbs_pkg::NUM_KEYS-1];
    logic [VB-1:0]                  scan_from;
    int                             held_count;

    t_sort_result expected_results [$];
    int           error_count;
    int           gap_pct;      // chance of an idle cycle before a word
    int           stall_pct;    // chance the receiver stalls on a cycle
    int           cycle_count;

    // Lowest key with a nonzero count at or above start; NUM_KEYS if none.
    function automatic int first_occupied(input int start);
        for (int k = start; k < cbs_pkg::NUM_KEYS; k++) begin
            if (key_tally[k] != '0)
                return k;
        end
        return cbs_pkg::NUM_KEYS;
    endfunction

    function automatic t_sort_result predict_sort(input logic req, input logic [VB-1:0] key);
        t_sort_result res;
        int           hit;
        int           next;
        res = '0;
        if (req == REQ_INSERT) begin
            if (key_tally[key] == cbs_pkg::COUNT_MAX) begin
                res.status = cbs_pkg::ST_FULL;  // dropped, nothing changes
            end else begin
                key_tally[key] = key_tally[key] + 1'b1;
                held_count++;
                if (key < scan_from)
                    scan_from = key;
                res.status = cbs_pkg::ST_INSERTED;
            end
        end else begin
            hit = first_occupied(scan_from);
            if (hit == cbs_pkg::NUM_KEYS) begin
                res.status = cbs_pkg::ST_EMPTY;
            end else begin
                key_tally[hit] = key_tally[hit] - 1'b1;
                held_count--;
                next = first_occupied(hit);
                if (next == cbs_pkg::NUM_KEYS) begin
                    res.last  = 1'b1;           // this pop drained the store
                    scan_from = '0;
                end else begin
                    scan_from = next[VB-1:0];
                end
                res.status = cbs_pkg::ST_POPPED;
                res.key    = hit[VB-1:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic set_idling(input int phase);
        case (phase)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 45; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 45; end
            default: begin gap_pct = 11; stall_pct = 11; end
        endcase
    endtask

    // Present one request word and hold it until accepted. Valid is only
    // written once per edge, so back-to-back words keep it high.
    task automatic send_word(input logic req, input logic [VB-1:0] key,
                             input logic typed, input t_sort_result want);
        t_sort_result res;
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_value    <= key;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        // Accepted at this edge: advance the predictor.
        res = predict_sort(req, key);
        expected_results.push_back(typed ? want : res);
    endtask

    // Random segment. Keys mix the full range, a hot cluster that builds
    // duplicates, single-bit and inverted single-bit patterns, and keys at or
    // below the current minimum so the scan start has to move down.
    task automatic run_random(input int n_words, input int pop_pct);
        logic [VB-1:0] key;
        logic [VB-1:0] hot_key;
        int            lowest;
        hot_key = VB'($urandom_range(cbs_pkg::NUM_KEYS - 1));
        repeat (n_words) begin
            lowest = first_occupied(0);
            case ($urandom_range(3))
                0: key = VB'($urandom_range(cbs_pkg::NUM_KEYS - 1));
                1: key = hot_key + VB'($urandom_range(3));
                2: begin
                    key = VB'(1) << $urandom_range(VB - 1);
                    if ($urandom_range(1))
                        key = ~key;
                end
                default: key = VB'($urandom_range((lowest == cbs_pkg::NUM_KEYS) ?
                                                  cbs_pkg::NUM_KEYS - 1 : lowest));
            endcase
            send_word(($urandom_range(99) < pop_pct) ? REQ_POP : REQ_INSERT, key, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall decided fresh each edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted result word against the oldest
    // expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_sort_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result word with none expected: status %0d value %0d",
                                          o_status, o_sorted_value));
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
                if (o_sorted_value !== want.key)
                    report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                              o_sorted_value, want.key));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b", o_last, want.last));
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int n;
        error_count = 0;
        cycle_count = 0;
        held_count  = 0;
        scan_from   = '0;
        for (int k = 0; k < cbs_pkg::NUM_KEYS; k++)
            key_tally[k] = '0;
        set_idling(0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, no idling.
        for (int r = 0; r < $size(directed_rows); r++)
            send_word(directed_rows[r].req, directed_rows[r].key,
                      directed_rows[r].typed, directed_rows[r].want);

        // Random segments, cycling through the idling settings.
        for (int seg = 0; seg < 8; seg++) begin
            set_idling(seg % 4);
            run_random(200, pop_mix[seg]);
        end

        // Drain everything in order, then one pop on the empty store.
        n = 0;
        while (held_count > 0) begin
            if (n % 64 == 0)
                set_idling((n / 64 + 1) % 4);
            send_word(REQ_POP, VB'($urandom_range(cbs_pkg::NUM_KEYS - 1)), 1'b0, '0);
            n++;
        end
        send_word(REQ_POP, {VB{1'b1}}, 1'b1, '{cbs_pkg::ST_EMPTY, {VB{1'b0}}, 1'b0});
        i_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sim.f]
design/cbs_pkg.sv
design/cbs_ram.sv
design/cbs_ctrl.sv
design/cbs_dp.sv
design/counting_bucket_sort.sv
bench/testbench.sv
